### src/gsfd_pkg.sv
// shared types, constants and crc function for the gas sensor frame decoder
package gsfd_pkg;

    // crc-8 parameters: polynomial x^8 + x^5 + x^4 + 1, no reflection
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // frame layout: three words of high byte, low byte, crc byte
    localparam logic [3:0] POS_FIRST = 4'd0;
    localparam logic [3:0] POS_LAST  = 4'd8;

    // byte role inside a word
    typedef enum logic [1:0] {
        SLOT_HI  = 2'd0,
        SLOT_LO  = 2'd1,
        SLOT_CRC = 2'd2
    } slot_t;

    // word index inside a frame
    localparam logic [1:0] WORD_CO2  = 2'd0;
    localparam logic [1:0] WORD_TEMP = 2'd1;
    localparam logic [1:0] WORD_HUM  = 2'd2;

    // scaling constants for the fixed point conversions
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    // one collected frame handed from the front to the back
    typedef struct packed {
        logic [15:0] co2_raw;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        failed;
        logic [1:0]  bad_idx;
    } frame_t;

    // absorb one byte into the crc, msb first, eight unrolled steps
    function automatic logic [7:0] crc_absorb(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### src/gas_sensor_frame_crc_decoder.sv
// top level of the gas sensor frame decoder
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte, frame_start           | in
//  output  | out_valid, out_stall, co2_ppm, temperature_centi,  | out
//          | humidity_centi, status, bad_word                   |
//
// one byte word is taken every cycle while in_stall is low; the crc is one
// unrolled step per byte; a result goes from the edge that takes its ninth
// byte through the queue write, then the multiply stage, then the output register
// reset clears the byte count, crc, failure flag, queue and stage valids
// in_stall rises only while the frame queue is full; out_stall holds the
// output register and backs up through the multiply stage into the queue
module gas_sensor_frame_crc_decoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        co2_ppm,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic               status,
    output logic [1:0]         bad_word
);

    logic             push, pop, full, not_empty;
    gsfd_pkg::frame_t push_frame, head_frame;

    assign in_stall = full;

    // byte parsing and checking
    gsfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .push        (push),
        .push_frame  (push_frame)
    );

    // frame queue
    gsfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head_frame (head_frame)
    );

    // scaling and result delivery
    gsfd_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (not_empty),
        .q_frame           (head_frame),
        .q_pop             (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .co2_ppm           (co2_ppm),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (status),
        .bad_word          (bad_word)
    );

endmodule

### src/gsfd_front.sv
// front end: byte counting, crc checking and word collection
module gsfd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_start,
    output logic                 push,
    output gsfd_pkg::frame_t     push_frame
);

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        failed_reg, failed_next;
    logic [1:0]  idx_reg, idx_next;
    logic [15:0] co2_reg, co2_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;

    logic        accept;
    logic [3:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic        failed_eff;
    logic [1:0]  idx_eff;
    logic [1:0]  word_idx;
    gsfd_pkg::slot_t slot;
    logic        fail_now;
    logic        last;

    assign accept = in_valid && !in_stall;

    // a start flag restarts the frame on this very word
    always_comb
    begin
        pos_eff    = frame_start ? gsfd_pkg::POS_FIRST : pos_reg;
        crc_eff    = frame_start ? gsfd_pkg::CRC_INIT : crc_reg;
        failed_eff = frame_start ? 1'b0 : failed_reg;
        idx_eff    = frame_start ? gsfd_pkg::WORD_CO2 : idx_reg;
    end

    // position to word index and byte role
    always_comb
    begin
        case (pos_eff)
            4'd0:    begin word_idx = gsfd_pkg::WORD_CO2;  slot = gsfd_pkg::SLOT_HI;  end
            4'd1:    begin word_idx = gsfd_pkg::WORD_CO2;  slot = gsfd_pkg::SLOT_LO;  end
            4'd2:    begin word_idx = gsfd_pkg::WORD_CO2;  slot = gsfd_pkg::SLOT_CRC; end
            4'd3:    begin word_idx = gsfd_pkg::WORD_TEMP; slot = gsfd_pkg::SLOT_HI;  end
            4'd4:    begin word_idx = gsfd_pkg::WORD_TEMP; slot = gsfd_pkg::SLOT_LO;  end
            4'd5:    begin word_idx = gsfd_pkg::WORD_TEMP; slot = gsfd_pkg::SLOT_CRC; end
            4'd6:    begin word_idx = gsfd_pkg::WORD_HUM;  slot = gsfd_pkg::SLOT_HI;  end
            4'd7:    begin word_idx = gsfd_pkg::WORD_HUM;  slot = gsfd_pkg::SLOT_LO;  end
            4'd8:    begin word_idx = gsfd_pkg::WORD_HUM;  slot = gsfd_pkg::SLOT_CRC; end
            default: begin word_idx = gsfd_pkg::WORD_CO2;  slot = gsfd_pkg::SLOT_HI;  end
        endcase
    end

    assign last     = (pos_eff == gsfd_pkg::POS_LAST);
    assign fail_now = (slot == gsfd_pkg::SLOT_CRC) && (crc_eff != rx_byte) && !failed_eff;

    // next state for one accepted word
    always_comb
    begin
        pos_next    = last ? gsfd_pkg::POS_FIRST : pos_eff + 4'd1;
        crc_next    = gsfd_pkg::CRC_INIT;
        failed_next = failed_eff || fail_now;
        idx_next    = fail_now ? word_idx : idx_eff;
        co2_next    = co2_reg;
        temp_next   = temp_reg;
        hum_next    = hum_reg;
        if (slot != gsfd_pkg::SLOT_CRC)
        begin
            crc_next = gsfd_pkg::crc_absorb(crc_eff, rx_byte);
            case (word_idx)
                gsfd_pkg::WORD_CO2:
                begin
                    if (slot == gsfd_pkg::SLOT_HI) co2_next = {rx_byte, co2_reg[7:0]};
                    else                           co2_next = {co2_reg[15:8], rx_byte};
                end
                gsfd_pkg::WORD_TEMP:
                begin
                    if (slot == gsfd_pkg::SLOT_HI) temp_next = {rx_byte, temp_reg[7:0]};
                    else                           temp_next = {temp_reg[15:8], rx_byte};
                end
                default:
                begin
                    if (slot == gsfd_pkg::SLOT_HI) hum_next = {rx_byte, hum_reg[7:0]};
                    else                           hum_next = {hum_reg[15:8], rx_byte};
                end
            endcase
        end
    end

    // frame handoff on the crc word of the third data word
    always_comb
    begin
        push                = accept && last;
        push_frame.co2_raw  = co2_reg;
        push_frame.temp_raw = temp_reg;
        push_frame.hum_raw  = hum_reg;
        push_frame.failed   = failed_next;
        push_frame.bad_idx  = idx_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= gsfd_pkg::POS_FIRST;
            crc_reg    <= gsfd_pkg::CRC_INIT;
            failed_reg <= 1'b0;
            idx_reg    <= gsfd_pkg::WORD_CO2;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            failed_reg <= last ? 1'b0 : failed_next;
            idx_reg    <= last ? gsfd_pkg::WORD_CO2 : idx_next;
        end
    end

    // collected data words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            co2_reg  <= co2_next;
            temp_reg <= temp_next;
            hum_reg  <= hum_next;
        end
    end

endmodule

### src/gsfd_queue.sv
// short frame queue between the front and back ends
module gsfd_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gsfd_pkg::frame_t push_frame,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output gsfd_pkg::frame_t head_frame
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    gsfd_pkg::frame_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;
    assign head_frame = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_frame;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### src/gsfd_back.sv
// back end: fixed point scaling and output register
module gsfd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  gsfd_pkg::frame_t   q_frame,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        co2_ppm,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic               status,
    output logic [1:0]         bad_word
);

    logic        p_valid_reg;
    logic [30:0] temp_prod_reg;
    logic [29:0] hum_prod_reg;
    logic [15:0] co2_reg;
    logic        failed_reg;
    logic [1:0]  idx_reg;

    logic        o_valid_reg;
    logic [15:0] o_co2_reg;
    logic [14:0] o_temp_reg, o_temp_next;
    logic [13:0] o_hum_reg;
    logic        o_status_reg;
    logic [1:0]  o_bad_reg;

    logic out_free, p_free, p_move;

    assign out_free = !o_valid_reg || !out_stall;
    assign p_move   = p_valid_reg && out_free;
    assign p_free   = !p_valid_reg || out_free;
    assign q_pop    = q_valid && p_free;

    // floor of the scaled temperature minus offset, wraps to 15 bits
    assign o_temp_next = temp_prod_reg[30:16] - gsfd_pkg::TEMP_OFFSET;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
                p_valid_reg <= q_valid;
            if (out_free)
                o_valid_reg <= p_valid_reg;
        end
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            temp_prod_reg <= q_frame.temp_raw * gsfd_pkg::TEMP_SCALE;
            hum_prod_reg  <= q_frame.hum_raw * gsfd_pkg::HUM_SCALE;
            co2_reg       <= q_frame.co2_raw;
            failed_reg    <= q_frame.failed;
            idx_reg       <= q_frame.bad_idx;
        end
    end

    // output register, zero values on a failed check
    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            o_co2_reg    <= failed_reg ? 16'd0 : co2_reg;
            o_temp_reg   <= failed_reg ? 15'd0 : o_temp_next;
            o_hum_reg    <= failed_reg ? 14'd0 : hum_prod_reg[29:16];
            o_status_reg <= failed_reg;
            o_bad_reg    <= failed_reg ? idx_reg : gsfd_pkg::WORD_CO2;
        end
    end

    assign out_valid         = o_valid_reg;
    assign co2_ppm           = o_co2_reg;
    assign temperature_centi = o_temp_reg;
    assign humidity_centi    = o_hum_reg;
    assign status            = o_status_reg;
    assign bad_word          = o_bad_reg;

endmodule

### src/gsfd_checker.sv
// port level checker for the gas sensor frame decoder, with its bind
module gsfd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [7:0]         rx_byte,
    input logic               frame_start,
    input logic               out_valid,
    input logic               out_stall,
    input logic [15:0]        co2_ppm,
    input logic signed [14:0] temperature_centi,
    input logic [13:0]        humidity_centi,
    input logic               status,
    input logic [1:0]         bad_word
);

    // a stalled result word stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(co2_ppm)
            && $stable(temperature_centi) && $stable(humidity_centi)
            && $stable(status) && $stable(bad_word))
        else $error("result word changed while stalled");

    // a stalled input word stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte) && $stable(frame_start))
        else $error("input word changed while stalled");

    // an error result carries zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> co2_ppm == 16'd0 && temperature_centi == 15'sd0
                                && humidity_centi == 14'd0)
        else $error("error result with nonzero values");

    // a good frame reports no failing word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> bad_word == 2'd0)
        else $error("good frame names a failing word");

    // humidity below full scale and word index within the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity_centi <= 14'd9999 && bad_word != 2'd3)
        else $error("result field out of range");

endmodule

bind gas_sensor_frame_crc_decoder gsfd_checker u_gsfd_checker (.*);

### tb/tb_gas_sensor_frame_crc_decoder.sv
// self-checking testbench for the gas sensor frame decoder
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_SLACK    = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_BYTES   = 1300;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_CRC   = 1'b1;

    // one decoded reading as it leaves the block
    typedef struct {
        logic [15:0]        co2_ppm;
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic               status;
        logic [1:0]         bad_word;
    } reading_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               frame_start;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        co2_ppm;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               status;
    logic [1:0]         bad_word;

    // decoder mirror state
    logic [3:0]  frame_pos;
    logic [7:0]  value_crc;
    logic [15:0] sensor_val [3];
    logic        crc_failed;
    logic [1:0]  failed_value;

    reading_t expected_readings [$];
    int       mismatches;
    int       bytes_sent;
    logic     tx_idle_en;
    logic     rx_idle_en;
    logic     hold_req;

    gas_sensor_frame_crc_decoder uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .co2_ppm           (co2_ppm),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (status),
        .bad_word          (bad_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // crc-8, bit serial, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[7] ^ data[i])
                r = {r[6:0], 1'b0} ^ gsfd_pkg::CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // drop any partial frame
    function automatic void start_new_frame();
        frame_pos    = gsfd_pkg::POS_FIRST;
        value_crc    = gsfd_pkg::CRC_INIT;
        crc_failed   = 1'b0;
        failed_value = gsfd_pkg::WORD_CO2;
    endfunction

    // advance the mirror by one accepted word, queue a reading after the ninth
    function automatic void decode_byte(input logic [7:0] b, input logic fs);
        logic [1:0]      idx;
        gsfd_pkg::slot_t slot;
        reading_t        r;
        logic [31:0]     temp_prod;
        logic [31:0]     hum_prod;
        if (fs)
            start_new_frame();
        idx  = 2'(frame_pos / 4'd3);
        slot = gsfd_pkg::slot_t'(frame_pos % 4'd3);
        if (slot == gsfd_pkg::SLOT_CRC)
        begin
            if (b != value_crc && !crc_failed)
            begin
                crc_failed   = 1'b1;
                failed_value = idx;
            end
            value_crc = gsfd_pkg::CRC_INIT;
        end
        else
        begin
            value_crc = crc8_next(value_crc, b);
            if (slot == gsfd_pkg::SLOT_HI)
                sensor_val[idx][15:8] = b;
            else
                sensor_val[idx][7:0] = b;
        end
        if (frame_pos != gsfd_pkg::POS_LAST)
        begin
            frame_pos = frame_pos + 4'd1;
            return;
        end
        if (crc_failed)
        begin
            r.co2_ppm    = '0;
            r.temp_centi = '0;
            r.hum_centi  = '0;
            r.status     = STATUS_CRC;
            r.bad_word   = failed_value;
        end
        else
        begin
            temp_prod    = 32'(sensor_val[gsfd_pkg::WORD_TEMP]) * 32'(gsfd_pkg::TEMP_SCALE);
            hum_prod     = 32'(sensor_val[gsfd_pkg::WORD_HUM]) * 32'(gsfd_pkg::HUM_SCALE);
            r.co2_ppm    = sensor_val[gsfd_pkg::WORD_CO2];
            r.temp_centi = temp_prod[30:16] - gsfd_pkg::TEMP_OFFSET;
            r.hum_centi  = hum_prod[29:16];
            r.status     = STATUS_OK;
            r.bad_word   = gsfd_pkg::WORD_CO2;
        end
        expected_readings.push_back(r);
        start_new_frame();
    endfunction

    // offer one word, hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 11) == 0)
            gap = $urandom_range(1, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid    = 1'b0;
            rx_byte     = 8'($urandom());
            frame_start = 1'($urandom());
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        rx_byte     = b;
        frame_start = fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, fs);
        bytes_sent++;
    endtask

    // one frame of three values, each followed by its crc; corrupt marks bad crcs
    task automatic send_frame(input logic [15:0] co2, input logic [15:0] temp,
                              input logic [15:0] hum, input logic [2:0] corrupt,
                              input logic flag);
        logic [15:0] vals [3];
        logic [7:0]  crc;
        vals = '{co2, temp, hum};
        for (int w = 0; w < 3; w++)
        begin
            crc = crc8_next(crc8_next(gsfd_pkg::CRC_INIT, vals[w][15:8]), vals[w][7:0]);
            if (corrupt[w])
                crc ^= 8'($urandom_range(1, 255));
            send_byte(vals[w][15:8], flag && w == 0);
            send_byte(vals[w][7:0], 1'b0);
            send_byte(crc, 1'b0);
        end
    endtask

    // sender stops until every queued reading has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_readings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // range ends of every field, flagged and unflagged frame starts
    task automatic test_value_extremes();
        send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 3'b000, 1'b1);
        send_frame(16'h0000, 16'hFFFF, 16'h0000, 3'b000, 1'b0);
    endtask

    // restart mid-frame, then a frame with two bad checks
    task automatic test_restart_mid_frame();
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h1234, 16'h8000, 16'h4000, 3'b110, 1'b1);
    endtask

    // mostly well-formed frames with random content, some noise and cut frames
    task automatic test_random_frames();
        int          kind;
        int          n;
        int          next_toggle;
        logic [2:0]  corrupt;
        next_toggle = bytes_sent;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= next_toggle)
            begin
                tx_idle_en  = $urandom_range(0, 3) != 0;
                rx_idle_en  = $urandom_range(0, 3) != 0;
                next_toggle = bytes_sent + $urandom_range(60, 200);
            end
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                for (int w = 0; w < 3; w++)
                    corrupt[w] = $urandom_range(0, 5) == 0;
                send_frame(rand_value(), rand_value(), rand_value(), corrupt,
                           $urandom_range(0, 3) != 0);
            end
            else if (kind == 8)
            begin
                // cut frame, the next flagged word restarts
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom()), i == 0);
                send_frame(rand_value(), rand_value(), rand_value(), 3'b000, 1'b1);
            end
            else
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // long receiver hold while the sender keeps going, so the input stalls
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        for (int f = 0; f < 12; f++)
            send_frame(rand_value(), rand_value(), rand_value(), 3'($urandom()), 1'b1);
        wait_drained();
    endtask

    // sender waits for an empty pipe between short bursts
    task automatic test_sender_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int r = 0; r < 6; r++)
        begin
            send_frame(rand_value(), rand_value(), rand_value(), 3'b000, 1'b1);
            send_frame(rand_value(), rand_value(), rand_value(), 3'($urandom()), 1'b0);
            wait_drained();
        end
    endtask

    // back to back frames with no idling on either side
    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int f = 0; f < 16; f++)
            send_frame(rand_value(), rand_value(), rand_value(),
                       ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'b000,
                       $urandom_range(0, 1) == 1);
    endtask

    // receiver stall: random bursts, or one long hold on request
    initial
    begin
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall = 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(0, 12);
                out_stall  = 1'b1;
            end
            else
                out_stall = 1'b0;
        end
    end

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%t mismatch %s: expected %0d, got %0d",
                         $realtime, name, exp_v, act_v);
        end
    endtask

    // compare each accepted reading with the oldest expected one
    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t unexpected reading: co2 %0d temp %0d hum %0d status %0d bad %0d",
                             $realtime, co2_ppm, temperature_centi, humidity_centi, status,
                             bad_word);
            end
            else
            begin
                want = expected_readings.pop_front();
                compare_field("co2_ppm", int'(want.co2_ppm), int'(co2_ppm));
                compare_field("temperature_centi", int'(want.temp_centi),
                              int'(temperature_centi));
                compare_field("humidity_centi", int'(want.hum_centi), int'(humidity_centi));
                compare_field("status", int'(want.status), int'(status));
                compare_field("bad_word", int'(want.bad_word), int'(bad_word));
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        frame_start = 1'b0;
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        hold_req    = 1'b0;
        mismatches  = 0;
        bytes_sent  = 0;
        sensor_val  = '{16'h0000, 16'h0000, 16'h0000};
        start_new_frame();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_value_extremes();
        test_restart_mid_frame();
        wait_drained();
        test_random_frames();
        wait_drained();
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();
        wait_drained();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
